// ----- hdl/roro_pkg.sv -----
package roro_pkg;

   localparam int HANDLE_BITS = 32;
   localparam int SIZE_BITS   = 16;
   localparam int POS_BITS    = 20;
   // width of the remaining-offset register and its compare against a size
   localparam int CMP_BITS    = (POS_BITS > SIZE_BITS) ? POS_BITS : SIZE_BITS;

   typedef enum logic {
      MODE_ADD  = 1'b0,
      MODE_FIND = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [HANDLE_BITS-1:0] record_handle;
      logic [SIZE_BITS-1:0]   record_size;
      logic [POS_BITS-1:0]    byte_position;
   } req_type;

   typedef struct packed {
      logic                   evicted_valid;
      logic [HANDLE_BITS-1:0] evicted_handle;
      logic                   found;
      logic [HANDLE_BITS-1:0] found_handle;
      logic [SIZE_BITS-1:0]   found_size;
      logic [SIZE_BITS-1:0]   offset_in_record;
   } rsp_type;

endpackage

// ----- hdl/roro_slots.sv -----
module roro_slots #(
   parameter int DEPTH = 10
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [roro_pkg::HANDLE_BITS-1:0]    wr_handle,
   input  logic [roro_pkg::SIZE_BITS-1:0]      wr_size,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [roro_pkg::HANDLE_BITS-1:0]    rd_handle,
   output logic [roro_pkg::SIZE_BITS-1:0]      rd_size
);
   import roro_pkg::*;

   logic [HANDLE_BITS-1:0] handle_mem [DEPTH];
   logic [SIZE_BITS-1:0]   size_mem   [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         handle_mem[wr_addr] <= wr_handle;
         size_mem[wr_addr]   <= wr_size;
      end
   end

   // registered read, one address per cycle
   always_ff @(posedge clock) begin
      rd_handle <= handle_mem[rd_addr];
      rd_size   <= size_mem[rd_addr];
   end

endmodule

// ----- hdl/ring_of_records_with_offset_lookup.sv -----
// Ring of DEPTH records (handle, byte size) that overwrites its oldest record
// when full. An add transaction stores a record and reports any evicted
// handle; a find transaction maps a byte offset into the oldest-first
// concatenation of the stored records onto a record and an offset inside it.
// Every request gives exactly one response. One request is in progress at a
// time: an add stores its record and then responds, a find on an empty ring
// goes to its response without walking, otherwise it walks n records (n is 1
// to DEPTH), one per cycle through a single subtract-and-compare unit
// fed by the one read port of the record store. A finished response sits in
// an output register, so the next request is taken while it waits.
module ring_of_records_with_offset_lookup #(
   parameter int DEPTH = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  roro_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output roro_pkg::rsp_type rsp_data
);
   import roro_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ADD  = 4'b0010,
      ST_WALK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   state_type state_ff, state_in;
   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          full_ff, full_in;
   logic [IW-1:0] walk_idx_ff, walk_idx_in;
   logic [CMP_BITS-1:0]    rem_ff, rem_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [SIZE_BITS-1:0]   size_ff, size_in;
   rsp_type res_ff, res_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                   mem_wr_en;
   logic [IW-1:0]          mem_rd_addr;
   logic [HANDLE_BITS-1:0] mem_rd_handle;
   logic [SIZE_BITS-1:0]   mem_rd_size;

   logic req_fire;
   logic ring_empty;
   logic ring_full;
   logic hit;
   logic [IW-1:0] walk_next;
   logic [IW-1:0] wr_next;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign ring_empty = !full_ff && (wr_idx_ff == rd_idx_ff);
   assign ring_full  = full_ff && (wr_idx_ff == rd_idx_ff);
   assign walk_next  = next_slot(walk_idx_ff);
   assign wr_next    = next_slot(wr_idx_ff);
   assign hit        = rem_ff < CMP_BITS'(mem_rd_size);

   // idle reads the oldest slot (also the slot an add on a full ring replaces)
   assign mem_rd_addr = (state_ff == ST_IDLE) ? rd_idx_ff : walk_next;
   assign mem_wr_en   = (state_ff == ST_ADD);

   roro_slots #(
      .DEPTH(DEPTH)
   ) u_slots (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (wr_idx_ff),
      .wr_handle (handle_ff),
      .wr_size   (size_ff),
      .rd_addr   (mem_rd_addr),
      .rd_handle (mem_rd_handle),
      .rd_size   (mem_rd_size)
   );

   always_comb begin
      state_in    = state_ff;
      wr_idx_in   = wr_idx_ff;
      rd_idx_in   = rd_idx_ff;
      full_in     = full_ff;
      walk_idx_in = walk_idx_ff;
      rem_in      = rem_ff;
      handle_in   = handle_ff;
      size_in     = size_ff;
      res_in      = res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               handle_in   = req_data.record_handle;
               size_in     = req_data.record_size;
               rem_in      = CMP_BITS'(req_data.byte_position);
               walk_idx_in = rd_idx_ff;
               res_in      = '0;
               if (req_data.mode == MODE_ADD) begin
                  state_in = ST_ADD;
               end else if (ring_empty) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_ADD: begin
            wr_idx_in = wr_next;
            if (ring_full) begin
               res_in.evicted_valid  = 1'b1;
               res_in.evicted_handle = mem_rd_handle;
               rd_idx_in             = wr_next;
            end else begin
               full_in = (wr_next == rd_idx_ff);
            end
            state_in = ST_DONE;
         end
         ST_WALK: begin
            // remaining offset below this record's size: the byte is here
            if (hit) begin
               res_in.found            = 1'b1;
               res_in.found_handle     = mem_rd_handle;
               res_in.found_size       = mem_rd_size;
               res_in.offset_in_record = SIZE_BITS'(rem_ff);
               state_in                = ST_DONE;
            end else begin
               rem_in      = rem_ff - CMP_BITS'(mem_rd_size);
               walk_idx_in = walk_next;
               if (walk_next == wr_idx_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff <= walk_idx_in;
      rem_ff      <= rem_in;
      handle_ff   <= handle_in;
      size_ff     <= size_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
